### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// shared types and constants of the binary trie max-xor block
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int KEY_BITS_DEF = 32;
  localparam int MAX_KEYS_DEF = 1024;

  // fixed field widths of the stream ports
  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int XOR_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY        = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY_INSERT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Q_START,
    ST_Q_STEP,
    ST_I_START,
    ST_I_STEP,
    ST_I_CHECK,
    ST_I_FILL,
    ST_DONE
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic accept;
    logic walk_start;
    logic set_valid;
    logic q_step;
    logic i_step;
    logic commit;
    logic fill;
    logic set_full;
    logic key_inc;
    logic out_load;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic empty;
    logic lvl_zero;
    logic div;
    logic fits;
  } stat_t;

endpackage

### sv/btmx_ram.sv
// ----------------------------------------------------------------------------
// btmx_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/btmx_seq.sv
// ----------------------------------------------------------------------------
// btmx_seq
// command sequencer: query walk, insert walk, allocation and fill
// ----------------------------------------------------------------------------
module btmx_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic [btmx_pkg::CMD_W-1:0]   cmd,
  input  btmx_pkg::stat_t              stat,
  input  logic                         out_free,
  output btmx_pkg::ctrl_t              ctrl,
  output btmx_pkg::state_t             state
);

  btmx_pkg::state_t            state_next;
  logic [btmx_pkg::CMD_W-1:0]  cmd_r;
  logic                        then_insert;

  assign then_insert = (cmd_r == btmx_pkg::CMD_QUERY_INSERT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btmx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == btmx_pkg::ST_IDLE && s_tvalid) begin
      cmd_r <= cmd;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btmx_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (cmd == btmx_pkg::CMD_INSERT) begin
            state_next = btmx_pkg::ST_I_START;
          end else if (cmd == btmx_pkg::CMD_QUERY || cmd == btmx_pkg::CMD_QUERY_INSERT) begin
            state_next = btmx_pkg::ST_Q_START;
          end else begin
            state_next = btmx_pkg::ST_DONE;
          end
        end
      end
      btmx_pkg::ST_Q_START: begin
        if (!stat.empty) begin
          state_next = btmx_pkg::ST_Q_STEP;
        end else if (then_insert) begin
          state_next = btmx_pkg::ST_I_START;
        end else begin
          state_next = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::ST_Q_STEP: begin
        if (stat.lvl_zero) begin
          state_next = then_insert ? btmx_pkg::ST_I_START : btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::ST_I_START: begin
        state_next = btmx_pkg::ST_I_STEP;
      end
      btmx_pkg::ST_I_STEP: begin
        if (stat.div) begin
          state_next = btmx_pkg::ST_I_CHECK;
        end else if (stat.lvl_zero) begin
          state_next = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::ST_I_CHECK: begin
        state_next = stat.fits ? btmx_pkg::ST_I_FILL : btmx_pkg::ST_DONE;
      end
      btmx_pkg::ST_I_FILL: begin
        if (stat.lvl_zero) begin
          state_next = btmx_pkg::ST_DONE;
        end
      end
      btmx_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = btmx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btmx_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      btmx_pkg::ST_IDLE: begin
        ctrl.accept = s_tvalid;
      end
      btmx_pkg::ST_Q_START: begin
        ctrl.walk_start = !stat.empty;
        ctrl.set_valid  = !stat.empty;
      end
      btmx_pkg::ST_Q_STEP: begin
        ctrl.q_step = 1'b1;
      end
      btmx_pkg::ST_I_START: begin
        ctrl.walk_start = 1'b1;
      end
      btmx_pkg::ST_I_STEP: begin
        ctrl.i_step  = 1'b1;
        // duplicate key: walk reached a leaf without a missing link
        ctrl.key_inc = !stat.div && stat.lvl_zero;
      end
      btmx_pkg::ST_I_CHECK: begin
        ctrl.commit   = stat.fits;
        ctrl.set_full = !stat.fits;
      end
      btmx_pkg::ST_I_FILL: begin
        ctrl.fill    = 1'b1;
        ctrl.key_inc = stat.lvl_zero;
      end
      btmx_pkg::ST_DONE: begin
        ctrl.out_load = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

### sv/btmx_path.sv
// ----------------------------------------------------------------------------
// btmx_path
// trie walk datapath: level counter, node pointer, link select, allocator
// ----------------------------------------------------------------------------
module btmx_path #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF,
  parameter int MAX_KEYS = btmx_pkg::MAX_KEYS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  btmx_pkg::ctrl_t                            ctrl,
  input  logic [btmx_pkg::KEY_W-1:0]                 key_in,
  output btmx_pkg::stat_t                            stat,
  output logic                                       ram_we,
  output logic [$clog2(MAX_KEYS*KEY_BITS+1)-1:0]     ram_waddr,
  output logic [2*$clog2(MAX_KEYS*KEY_BITS+1)-1:0]   ram_wdata,
  output logic [$clog2(MAX_KEYS*KEY_BITS+1)-1:0]     ram_raddr,
  input  logic [2*$clog2(MAX_KEYS*KEY_BITS+1)-1:0]   ram_rdata,
  output logic [btmx_pkg::XOR_W-1:0]                 res_xor,
  output logic                                       res_valid,
  output logic                                       res_full
);

  localparam int NODE_CAP = MAX_KEYS * KEY_BITS;
  localparam int NODE_W   = $clog2(NODE_CAP + 1);
  localparam int ROW_W    = 2 * NODE_W;
  localparam int LVL_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int KEYS_W   = $clog2(MAX_KEYS + 1);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] acc;
  logic [LVL_W-1:0]    lvl;
  logic [LVL_W-1:0]    lvl_m1;
  logic [NODE_W-1:0]   cur_node;
  logic [NODE_W-1:0]   par_node;
  logic [ROW_W-1:0]    par_row;
  logic [NODE_W-1:0]   nodes_used;
  logic [KEYS_W-1:0]   keys_stored;
  logic                root_written;

  logic [ROW_W-1:0]    row_eff;
  logic [NODE_W-1:0]   c0;
  logic [NODE_W-1:0]   c1;
  logic                bit_cur;
  logic                bit_nxt;
  logic [NODE_W-1:0]   c_same;
  logic [NODE_W-1:0]   c_other;
  logic                take;
  logic [NODE_W-1:0]   q_next;
  logic [NODE_W-1:0]   new_node;
  logic [NODE_W:0]     need_sum;
  logic [ROW_W-1:0]    commit_row;
  logic [ROW_W-1:0]    fill_row;

  // root row is not in memory until the first accepted insert writes it
  assign row_eff  = (cur_node == '0 && !root_written) ? '0 : ram_rdata;
  assign c0       = row_eff[NODE_W-1:0];
  assign c1       = row_eff[ROW_W-1:NODE_W];
  assign lvl_m1   = lvl - LVL_W'(1);
  assign bit_cur  = key_r[lvl];
  assign bit_nxt  = key_r[lvl_m1];
  assign c_same   = bit_cur ? c1 : c0;
  assign c_other  = bit_cur ? c0 : c1;
  assign take     = (c_other != '0);
  assign q_next   = take ? c_other : c_same;
  assign new_node = nodes_used + NODE_W'(1);
  assign need_sum = {1'b0, nodes_used} + (NODE_W+1)'(lvl) + (NODE_W+1)'(1);

  assign commit_row = bit_cur ? {new_node, par_row[NODE_W-1:0]}
                              : {par_row[ROW_W-1:NODE_W], new_node};
  assign fill_row   = bit_nxt ? {new_node, NODE_W'(0)} : {NODE_W'(0), new_node};

  assign stat.empty    = (keys_stored == '0);
  assign stat.lvl_zero = (lvl == '0);
  assign stat.div      = (c_same == '0);
  assign stat.fits     = (need_sum <= (NODE_W+1)'(NODE_CAP));

  assign ram_we    = ctrl.commit || ctrl.fill;
  assign ram_waddr = ctrl.commit ? par_node : cur_node;
  assign ram_wdata = ctrl.commit ? commit_row : ((lvl == '0) ? '0 : fill_row);
  assign ram_raddr = ctrl.walk_start ? '0 : (ctrl.q_step ? q_next : c_same);

  assign res_xor = btmx_pkg::XOR_W'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used   <= '0;
      keys_stored  <= '0;
      root_written <= 1'b0;
    end else begin
      if (ctrl.commit) begin
        nodes_used <= new_node;
        if (par_node == '0) begin
          root_written <= 1'b1;
        end
      end else if (ctrl.fill && lvl != '0) begin
        nodes_used <= new_node;
      end
      if (ctrl.key_inc && keys_stored != KEYS_W'(MAX_KEYS)) begin
        keys_stored <= keys_stored + KEYS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      key_r     <= KEY_BITS'(key_in);
      acc       <= '0;
      res_valid <= 1'b0;
      res_full  <= 1'b0;
    end
    if (ctrl.set_valid) begin
      res_valid <= 1'b1;
    end
    if (ctrl.set_full) begin
      res_full <= 1'b1;
    end
    if (ctrl.walk_start) begin
      lvl      <= LVL_W'(KEY_BITS - 1);
      cur_node <= '0;
    end
    if (ctrl.q_step) begin
      acc[lvl] <= take;
      cur_node <= q_next;
      lvl      <= lvl_m1;
    end
    if (ctrl.i_step) begin
      if (c_same == '0) begin
        par_node <= cur_node;
        par_row  <= row_eff;
      end else begin
        cur_node <= c_same;
        lvl      <= lvl_m1;
      end
    end
    if (ctrl.commit) begin
      cur_node <= new_node;
    end
    if (ctrl.fill && lvl != '0) begin
      cur_node <= new_node;
      lvl      <= lvl_m1;
    end
  end

endmodule

### sv/binary_trie_max_xor.sv
// query: walk from the root through every key level; insert: walk, check, fill
// query then insert: both in turn; next request taken the cycle after output load
// cost is one trie level per cycle through the single read port of the node memory
// the finished result sits in an output register, so the next request may enter
// reset clears the node count, key count and root flag; node memory needs no
// clearing pass, each node row is written when the node is allocated
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// bounded binary trie with insert and maximum-xor query over stored keys
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_trie_max_xor #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF,
  parameter int MAX_KEYS = btmx_pkg::MAX_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[31:0]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // max_xor[31:0]
  output logic [1:0]  m_tuser    // result_valid[0], pool_full[1]
);

  localparam int NODE_CAP = MAX_KEYS * KEY_BITS;
  localparam int NODE_W   = $clog2(NODE_CAP + 1);
  localparam int ROW_W    = 2 * NODE_W;

  btmx_pkg::ctrl_t                ctrl;
  btmx_pkg::stat_t                stat;
  btmx_pkg::state_t               state;
  logic                           out_free;
  logic                           ram_we;
  logic [NODE_W-1:0]              ram_waddr;
  logic [ROW_W-1:0]               ram_wdata;
  logic [NODE_W-1:0]              ram_raddr;
  logic [ROW_W-1:0]               ram_rdata;
  logic [btmx_pkg::XOR_W-1:0]     res_xor;
  logic                           res_valid;
  logic                           res_full;

  assign s_tready = (state == btmx_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  btmx_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .cmd      (s_tuser),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .state    (state)
  );

  btmx_path #(
    .KEY_BITS (KEY_BITS),
    .MAX_KEYS (MAX_KEYS)
  ) u_path (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .key_in    (s_tdata),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_xor   (res_xor),
    .res_valid (res_valid),
    .res_full  (res_full)
  );

  // one row per node: {child_one, child_zero}
  btmx_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_CAP + 1)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= res_xor;
      m_tuser <= {res_full, res_valid};
    end
  end

  `ASSERT_IMPL(a_write_in_insert, clk, rst, ram_we,
    (state == btmx_pkg::ST_I_CHECK || state == btmx_pkg::ST_I_FILL),
    "node memory written outside insert allocation")

  `ASSERT_NEXT(a_one_in_flight, clk, rst, (s_tvalid && s_tready), !s_tready,
    "second request taken while one is in flight")

  `ASSERT_IMPL(a_load_when_free, clk, rst, ctrl.out_load, (!m_tvalid || m_tready),
    "result loaded over an untaken result")

endmodule

### dv/binary_trie_max_xor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_test
// Drives insert, query and query-then-insert requests into the trie block.
// A scoreboard keeps its own trie to predict every result, then checks the
// results in order. The run covers the empty trie, duplicate keys and the
// unused command.
// ----------------------------------------------------------------------------

localparam int TRIE_NODES = btmx_pkg::MAX_KEYS_DEF * btmx_pkg::KEY_BITS_DEF;
localparam logic [btmx_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

typedef struct {
  logic [btmx_pkg::CMD_W-1:0] cmd;
  logic [btmx_pkg::KEY_W-1:0] key;
  logic [btmx_pkg::XOR_W-1:0] max_xor;
  logic                       result_valid;
  logic                       pool_full;
} xor_result_t;

class max_xor_scoreboard;
  bit [15:0]   zero_link [TRIE_NODES+1];
  bit [15:0]   one_link [TRIE_NODES+1];
  int          nodes_used;
  int          keys_stored;
  int          errors;
  xor_result_t awaited[$];

  function int free_nodes();
    return TRIE_NODES - nodes_used;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function int child(int node, bit b);
    return b ? one_link[node] : zero_link[node];
  endfunction

  // greedy walk, taking the opposite bit wherever that branch exists
  function void best_xor(logic [btmx_pkg::KEY_W-1:0] key,
                         output logic [btmx_pkg::XOR_W-1:0] best,
                         output logic found);
    int node;
    int nxt;
    node = 0;
    best = '0;
    found = (keys_stored != 0);
    if (!found) return;
    for (int lvl = btmx_pkg::KEY_BITS_DEF - 1; lvl >= 0; lvl--) begin
      nxt = child(node, !key[lvl]);
      if (nxt != 0) begin
        best[lvl] = 1'b1;
        node = nxt;
      end else begin
        node = child(node, key[lvl]);
      end
    end
  endfunction

  // returns 1 when the pool cannot hold the new path
  function logic add_key(logic [btmx_pkg::KEY_W-1:0] key);
    int node;
    int nxt;
    int need;
    node = 0;
    need = 0;
    for (int lvl = btmx_pkg::KEY_BITS_DEF - 1; lvl >= 0; lvl--) begin
      nxt = (need > 0) ? 0 : child(node, key[lvl]);
      if (nxt == 0) need++;
      node = nxt;
    end
    if (need > free_nodes()) return 1'b1;
    node = 0;
    for (int lvl = btmx_pkg::KEY_BITS_DEF - 1; lvl >= 0; lvl--) begin
      nxt = child(node, key[lvl]);
      if (nxt == 0) begin
        nodes_used++;
        nxt = nodes_used;
        if (key[lvl]) one_link[node] = 16'(nxt);
        else zero_link[node] = 16'(nxt);
      end
      node = nxt;
    end
    if (keys_stored < btmx_pkg::MAX_KEYS_DEF) keys_stored++;
    return 1'b0;
  endfunction

  function void note_request(logic [btmx_pkg::CMD_W-1:0] cmd,
                             logic [btmx_pkg::KEY_W-1:0] key);
    xor_result_t r;
    r.cmd = cmd;
    r.key = key;
    r.max_xor = '0;
    r.result_valid = 1'b0;
    r.pool_full = 1'b0;
    if (cmd == btmx_pkg::CMD_QUERY || cmd == btmx_pkg::CMD_QUERY_INSERT) begin
      best_xor(key, r.max_xor, r.result_valid);
    end
    if (cmd == btmx_pkg::CMD_INSERT || cmd == btmx_pkg::CMD_QUERY_INSERT) begin
      r.pool_full = add_key(key);
    end
    awaited = {awaited, r};
  endfunction

  function void check_result(logic [btmx_pkg::XOR_W-1:0] data, logic [1:0] user);
    xor_result_t r;
    if (awaited.size() == 0) begin
      errors++;
      $error("result with no request pending: max_xor %h flags %b", data, user);
      return;
    end
    r = awaited.pop_front();
    if (data !== r.max_xor) begin
      errors++;
      $error("max_xor: expected %h, got %h (cmd %0d key %h)", r.max_xor, data, r.cmd, r.key);
    end
    if (user[0] !== r.result_valid) begin
      errors++;
      $error("result_valid: expected %b, got %b (cmd %0d key %h)",
             r.result_valid, user[0], r.cmd, r.key);
    end
    if (user[1] !== r.pool_full) begin
      errors++;
      $error("pool_full: expected %b, got %b (cmd %0d key %h)",
             r.pool_full, user[1], r.cmd, r.key);
    end
  endfunction
endclass

module binary_trie_max_xor_test;
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [btmx_pkg::KEY_W-1:0] s_tdata = '0;
  logic [btmx_pkg::CMD_W-1:0] s_tuser = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [btmx_pkg::XOR_W-1:0] m_tdata;
  logic [1:0]                 m_tuser;

  max_xor_scoreboard          sb = new();
  logic [btmx_pkg::KEY_W-1:0] stored_keys[$];
  int                         sent = 0;
  int                         results_seen = 0;

  binary_trie_max_xor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_request(logic [btmx_pkg::CMD_W-1:0] cmd,
                              logic [btmx_pkg::KEY_W-1:0] key);
    int gap;
    // every so often a run of back-to-back requests
    gap = ((sent % 96) >= 72) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= key;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, key);
    sent++;
    if (cmd == btmx_pkg::CMD_INSERT || cmd == btmx_pkg::CMD_QUERY_INSERT) begin
      stored_keys = {stored_keys, key};
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_request();
    logic [btmx_pkg::CMD_W-1:0] cmd;
    logic [btmx_pkg::KEY_W-1:0] key;
    int                         pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = btmx_pkg::CMD_INSERT;
    else if (pick < 70) cmd = btmx_pkg::CMD_QUERY;
    else if (pick < 95) cmd = btmx_pkg::CMD_QUERY_INSERT;
    else cmd = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    key = $urandom;
    if (stored_keys.size() > 0 && pick >= 5 && pick <= 7) begin
      // close to a stored key, so the walk follows a long shared prefix
      key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
            ^ (key & ((32'd1 << $urandom_range(1, 16)) - 32'd1));
    end else if (stored_keys.size() > 0 && pick == 8) begin
      key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end else if (pick == 9) begin
      key = ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0) ^ (32'd1 << $urandom_range(0, 31));
    end
    send_request(cmd, key);
  endtask

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      // one long hold-off so the block backs up into the request side
      if (results_seen == 150) stall = 400;
      else if ((results_seen % 80) >= 60) stall = 0;
      else stall = $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
      results_seen++;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(btmx_pkg::CMD_QUERY, 32'h0000_0000);          // empty trie
    send_request(btmx_pkg::CMD_QUERY_INSERT, 32'h0000_0000);   // empty, then first key
    send_request(btmx_pkg::CMD_QUERY, 32'hFFFF_FFFF);
    send_request(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_request(btmx_pkg::CMD_QUERY, 32'h0000_0000);
    send_request(btmx_pkg::CMD_QUERY, 32'h8000_0001);
    send_request(btmx_pkg::CMD_INSERT, 32'h0000_0000);         // duplicate
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 32'h0000_0000);
    send_request(btmx_pkg::CMD_QUERY_INSERT, 32'h8000_0000);
    send_request(btmx_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_request(btmx_pkg::CMD_INSERT, 32'h0000_0001);
    send_request(btmx_pkg::CMD_QUERY, 32'h5555_5555);
    send_request(btmx_pkg::CMD_QUERY, 32'hAAAA_AAAA);
    send_request(btmx_pkg::CMD_QUERY_INSERT, 32'h1234_5678);
    send_request(btmx_pkg::CMD_QUERY_INSERT, 32'h1234_5678);   // duplicate through query-insert
    send_request(btmx_pkg::CMD_QUERY, 32'hEDCB_A987);
    drain();

    repeat (790) random_request();
    drain();

    repeat (43) random_request();
    drain();
    repeat (150) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/btmx_pkg.sv
sv/btmx_ram.sv
sv/btmx_seq.sv
sv/btmx_path.sv
sv/binary_trie_max_xor.sv
dv/binary_trie_max_xor_test.sv
